// ----- rtl/core/gagfe_pkg.sv -----
// ----------------------------------------------------------------------------
// gagfe_pkg
// Shared types, constants and decode functions for the GPS acknowledge
// matcher and GGA field extractor.
// ----------------------------------------------------------------------------
package gagfe_pkg;

    localparam int AckLen       = 10;
    localparam int HeaderLen    = 6;
    localparam int MaxSentence  = 82;

    localparam logic [3:0] ACK_LEN_C      = 4'(AckLen);
    localparam logic [6:0] HEADER_LEN_C   = 7'(HeaderLen);
    localparam logic [6:0] MAX_SENTENCE_C = 7'(MaxSentence);
    localparam logic [3:0] FIELD_FIRST    = 4'd1;
    localparam logic [3:0] FIELD_LAST     = 4'd15;
    localparam logic [3:0] POS_LAST       = 4'd15;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_G      = 8'h47;
    localparam logic [7:0] CHAR_A      = 8'h41;

    typedef struct packed {
        logic resend_setup;
        logic receiver_ready;
    } ack_res_t;

    typedef struct packed {
        logic       char_valid;
        logic [3:0] field_number;
        logic [3:0] char_position;
        logic [7:0] char_value;
        logic       sentence_end;
    } ext_res_t;

    function automatic logic [7:0] ack_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'hB5;
            4'd1:    b = 8'h62;
            4'd2:    b = 8'h05;
            4'd3:    b = 8'h01;
            4'd4:    b = 8'h02;
            4'd5:    b = 8'h00;
            4'd6:    b = 8'h06;
            4'd7:    b = 8'h24;
            4'd8:    b = 8'h32;
            4'd9:    b = 8'h5B;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic field_is_stored(input logic [3:0] f);
        return ((f >= 4'd1) && (f <= 4'd5)) || (f == 4'd7) ||
               ((f >= 4'd9) && (f <= 4'd12));
    endfunction

    function automatic logic header_byte_ok(input logic [2:0] pos, input logic [7:0] c);
        logic ok;
        case (pos)
            3'd0:    ok = (c == CHAR_DOLLAR);
            3'd1:    ok = (c == CHAR_G);
            3'd3:    ok = (c == CHAR_G);
            3'd4:    ok = (c == CHAR_G);
            3'd5:    ok = (c == CHAR_A);
            default: ok = 1'b1;
        endcase
        return ok;
    endfunction

endpackage

// ----- rtl/core/gagfe_ack_match.sv -----
// ----------------------------------------------------------------------------
// gagfe_ack_match
// Matches incoming bytes against the ten-byte acknowledge packet and holds
// the receiver-ready flag once the full packet has been seen.
// ----------------------------------------------------------------------------
module gagfe_ack_match (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [7:0]          rx_byte,
    output logic                ready_now,
    output gagfe_pkg::ack_res_t res
);
    import gagfe_pkg::*;

    logic [3:0] idx_reg, idx_next;
    logic       ready_reg, ready_next;
    logic       hit;

    always_comb
    begin
        hit        = (idx_reg < ACK_LEN_C) && (rx_byte == ack_byte(idx_reg));
        idx_next   = idx_reg;
        ready_next = ready_reg;
        res.resend_setup = 1'b0;
        if (!ready_reg)
        begin
            if (hit)
            begin
                idx_next = idx_reg + 4'd1;
            end
            else
            begin
                idx_next         = 4'd0;
                res.resend_setup = 1'b1;
            end
            if (idx_next >= ACK_LEN_C)
            begin
                ready_next = 1'b1;
            end
        end
        res.receiver_ready = ready_next;
    end

    assign ready_now = ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 4'd0;
            ready_reg <= 1'b0;
        end
        else if (advance)
        begin
            idx_reg   <= idx_next;
            ready_reg <= ready_next;
        end
    end

endmodule

// ----- rtl/core/gagfe_gga_extract.sv -----
// ----------------------------------------------------------------------------
// gagfe_gga_extract
// Tracks sentence framing, checks the $G?GGA header and tags each stored
// field character with its field number and position.
// ----------------------------------------------------------------------------
module gagfe_gga_extract (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                active,
    input  logic [7:0]          rx_byte,
    output gagfe_pkg::ext_res_t res
);
    import gagfe_pkg::*;

    logic       in_sent_reg, in_sent_next;
    logic [6:0] spos_reg, spos_next;
    logic       hgood_reg, hgood_next;
    logic [3:0] field_reg, field_next;
    logic [3:0] fcnt_reg, fcnt_next;

    logic       start;
    logic       busy;
    logic [6:0] pos;
    logic [6:0] npos;
    logic       is_star;
    logic       closing;

    always_comb
    begin
        is_star = (rx_byte == CHAR_STAR);
        start   = active && !in_sent_reg && (rx_byte == CHAR_DOLLAR);
        busy    = active && (in_sent_reg || start);
        pos     = start ? 7'd0 : spos_reg;
        npos    = pos + 7'd1;
        closing = is_star || (npos >= MAX_SENTENCE_C);

        in_sent_next = in_sent_reg;
        spos_next    = spos_reg;
        hgood_next   = start ? 1'b1 : hgood_reg;
        field_next   = start ? FIELD_FIRST : field_reg;
        fcnt_next    = start ? 4'd0 : fcnt_reg;
        res          = '0;

        if (busy)
        begin
            if (pos < HEADER_LEN_C)
            begin
                if (!header_byte_ok(pos[2:0], rx_byte))
                begin
                    hgood_next = 1'b0;
                end
            end
            else if ((pos > HEADER_LEN_C) && !is_star)
            begin
                if (rx_byte == CHAR_COMMA)
                begin
                    if (field_next < FIELD_LAST)
                    begin
                        field_next = field_next + 4'd1;
                    end
                    fcnt_next = 4'd0;
                end
                else
                begin
                    if (field_is_stored(field_next))
                    begin
                        res.char_valid    = 1'b1;
                        res.field_number  = field_next;
                        res.char_position = fcnt_next;
                        res.char_value    = rx_byte;
                    end
                    if (fcnt_next < POS_LAST)
                    begin
                        fcnt_next = fcnt_next + 4'd1;
                    end
                end
            end

            if (closing)
            begin
                res.sentence_end = hgood_next && (npos >= HEADER_LEN_C);
                in_sent_next     = 1'b0;
                spos_next        = 7'd0;
            end
            else if ((npos == HEADER_LEN_C) && !hgood_next)
            begin
                in_sent_next = 1'b0;
                spos_next    = 7'd0;
            end
            else
            begin
                in_sent_next = 1'b1;
                spos_next    = npos;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sent_reg <= 1'b0;
            spos_reg    <= 7'd0;
            hgood_reg   <= 1'b1;
            field_reg   <= FIELD_FIRST;
            fcnt_reg    <= 4'd0;
        end
        else if (advance)
        begin
            in_sent_reg <= in_sent_next;
            spos_reg    <= spos_next;
            hgood_reg   <= hgood_next;
            field_reg   <= field_next;
            fcnt_reg    <= fcnt_next;
        end
    end

endmodule

// ----- rtl/core/gps_ack_and_gga_field_extractor_top.sv -----
// ----------------------------------------------------------------------------
// gps_ack_and_gga_field_extractor_top
// Acknowledge matcher and GGA field extractor with registered input and
// result stages.
// ----------------------------------------------------------------------------
// One byte enters per cycle while the output is not stalled, and each byte
// yields exactly one result transaction, passing through the input register,
// then the result register. The sustained rate is one byte per cycle when
// out_stall is low, set by the single per-byte update of the matcher and
// sentence state between the two registers. Until the acknowledge packet has
// matched, receiver_ready is 0 and every mismatching byte raises
// resend_setup; afterwards GGA field characters come out with char_valid
// set, and sentence_end marks the byte that closes an accepted sentence.
module gps_ack_and_gga_field_extractor_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       resend_setup,
    output logic       receiver_ready,
    output logic       char_valid,
    output logic [3:0] field_number,
    output logic [3:0] char_position,
    output logic [7:0] char_value,
    output logic       sentence_end
);
    import gagfe_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    ack_res_t   ack_res_reg;
    ext_res_t   ext_res_reg;

    logic       out_free;
    logic       move;
    logic       in_take;
    logic       ready_now;
    ack_res_t   ack_res;
    ext_res_t   ext_res;

    assign out_free = !out_valid_reg || !out_stall;
    assign move     = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    assign in_valid_next  = in_take || (in_valid_reg && !move);
    assign out_valid_next = move || (out_valid_reg && out_stall);

    gagfe_ack_match u_ack (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (move),
        .rx_byte   (in_byte_reg),
        .ready_now (ready_now),
        .res       (ack_res)
    );

    gagfe_gga_extract u_ext (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (move),
        .active  (ready_now),
        .rx_byte (in_byte_reg),
        .res     (ext_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= rx_byte;
        end
        if (move)
        begin
            ack_res_reg <= ack_res;
            ext_res_reg <= ext_res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign resend_setup   = ack_res_reg.resend_setup;
    assign receiver_ready = ack_res_reg.receiver_ready;
    assign char_valid     = ext_res_reg.char_valid;
    assign field_number   = ext_res_reg.field_number;
    assign char_position  = ext_res_reg.char_position;
    assign char_value     = ext_res_reg.char_value;
    assign sentence_end   = ext_res_reg.sentence_end;

endmodule

// ----- rtl/core/gagfe_checker.sv -----
// ----------------------------------------------------------------------------
// gagfe_checker
// Port-level checks on the result transactions of the extractor top level.
// ----------------------------------------------------------------------------
module gagfe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       resend_setup,
    input logic       receiver_ready,
    input logic       char_valid,
    input logic [3:0] field_number,
    input logic [3:0] char_position,
    input logic [7:0] char_value,
    input logic       sentence_end
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(char_value)
            && $stable(field_number) && $stable(char_valid))
        else $error("result changed while stalled");

    a_resend_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && resend_setup |-> !receiver_ready && !char_valid && !sentence_end)
        else $error("resend request together with ready or sentence output");

    a_char_needs_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (char_valid || sentence_end) |-> receiver_ready)
        else $error("sentence output before receiver ready");

    a_stored_field: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && char_valid |->
            field_number == 4'd1 || field_number == 4'd2 || field_number == 4'd3 ||
            field_number == 4'd4 || field_number == 4'd5 || field_number == 4'd7 ||
            field_number == 4'd9 || field_number == 4'd10 ||
            field_number == 4'd11 || field_number == 4'd12)
        else $error("character emitted for an unstored field");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !char_valid |->
            field_number == 4'd0 && char_position == 4'd0 && char_value == 8'd0)
        else $error("field tags set without a character");

endmodule

bind gps_ack_and_gga_field_extractor_top gagfe_checker u_gagfe_checker (.*);

// ----- verif/tb_gps_ack_and_gga_field_extractor_top.sv -----
// ----------------------------------------------------------------------------
// tb_gps_ack_and_gga_field_extractor_top
// Self-checking bench for the acknowledge matcher and GGA field extractor.
// Bytes are driven over the valid/stall input channel with random gaps. An
// in-bench model of the matcher and sentence state predicts one result per
// accepted byte. A monitor compares every result transaction field by field
// against the oldest prediction. Traffic covers acknowledge mismatches, well
// formed and broken GGA sentences, length and field limits, and long output
// back-pressure.
// ----------------------------------------------------------------------------
module tb_gps_ack_and_gga_field_extractor_top;

    import gagfe_pkg::*;

    localparam logic [79:0] ACK_SEQUENCE = 80'hB5_62_05_01_02_00_06_24_32_5B;
    localparam int          RUN_LIMIT    = 5_000_000;

    typedef struct packed {
        ack_res_t ack;
        ext_res_t ext;
    } gps_result_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_stall;
    logic       resend_setup;
    logic       receiver_ready;
    logic       char_valid;
    logic [3:0] field_number;
    logic [3:0] char_position;
    logic [7:0] char_value;
    logic       sentence_end;

    // model state
    logic [3:0] ack_index;
    logic       ready_seen;
    logic       inside_sentence;
    logic [6:0] sentence_pos;
    logic       header_ok;
    logic [3:0] field_idx;
    logic [3:0] field_pos;

    gps_result_t expected_q[$];
    int          error_count;
    int          bytes_sent;
    int          tx_max_gap;
    int          rx_max_gap;
    int          hold_request;

    gps_ack_and_gga_field_extractor_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .resend_setup   (resend_setup),
        .receiver_ready (receiver_ready),
        .char_valid     (char_valid),
        .field_number   (field_number),
        .char_position  (char_position),
        .char_value     (char_value),
        .sentence_end   (sentence_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
        end
    endtask

    task automatic clear_model();
        ack_index       = '0;
        ready_seen      = 1'b0;
        inside_sentence = 1'b0;
        sentence_pos    = '0;
        header_ok       = 1'b1;
        field_idx       = FIELD_FIRST;
        field_pos       = '0;
    endtask

    function automatic logic gga_field_kept(input logic [3:0] f);
        return (f inside {[4'd1:4'd5], 4'd7, [4'd9:4'd12]});
    endfunction

    function automatic logic talker_char_ok(input logic [6:0] pos, input logic [7:0] c);
        logic ok;
        ok = 1'b1;
        case (pos)
            7'd0:              ok = (c == CHAR_DOLLAR);
            7'd1, 7'd3, 7'd4:  ok = (c == CHAR_G);
            7'd5:              ok = (c == CHAR_A);
            default:           ok = 1'b1;
        endcase
        return ok;
    endfunction

    task automatic extract_byte(input logic [7:0] c);
        gps_result_t r;
        logic [6:0]  pos;
        logic [6:0]  npos;
        logic        closing;
        r = '0;
        if (!ready_seen)
        begin
            if (ack_index < ACK_LEN_C && c == ACK_SEQUENCE[79 - 8 * ack_index -: 8])
            begin
                ack_index = ack_index + 4'd1;
            end
            else
            begin
                ack_index = '0;
                r.ack.resend_setup = 1'b1;
            end
            if (ack_index >= ACK_LEN_C)
            begin
                ready_seen = 1'b1;
            end
        end
        else
        begin
            if (!inside_sentence && c == CHAR_DOLLAR)
            begin
                inside_sentence = 1'b1;
                sentence_pos    = '0;
                header_ok       = 1'b1;
                field_idx       = FIELD_FIRST;
                field_pos       = '0;
            end
            if (inside_sentence)
            begin
                pos     = sentence_pos;
                npos    = pos + 7'd1;
                closing = (c == CHAR_STAR) || (npos >= MAX_SENTENCE_C);
                if (pos < HEADER_LEN_C)
                begin
                    if (!talker_char_ok(pos, c))
                    begin
                        header_ok = 1'b0;
                    end
                end
                else if (pos > HEADER_LEN_C && c != CHAR_STAR)
                begin
                    if (c == CHAR_COMMA)
                    begin
                        if (field_idx < FIELD_LAST)
                        begin
                            field_idx = field_idx + 4'd1;
                        end
                        field_pos = '0;
                    end
                    else
                    begin
                        if (gga_field_kept(field_idx))
                        begin
                            r.ext.char_valid    = 1'b1;
                            r.ext.field_number  = field_idx;
                            r.ext.char_position = field_pos;
                            r.ext.char_value    = c;
                        end
                        if (field_pos < POS_LAST)
                        begin
                            field_pos = field_pos + 4'd1;
                        end
                    end
                end
                if (closing)
                begin
                    r.ext.sentence_end = header_ok && (npos >= HEADER_LEN_C);
                    inside_sentence    = 1'b0;
                    sentence_pos       = '0;
                end
                else if (npos == HEADER_LEN_C && !header_ok)
                begin
                    inside_sentence = 1'b0;
                    sentence_pos    = '0;
                end
                else
                begin
                    sentence_pos = npos;
                end
            end
        end
        r.ack.receiver_ready = ready_seen;
        expected_q.push_back(r);
    endtask

    task automatic check_result();
        gps_result_t want;
        if (expected_q.size() == 0)
        begin
            report_mismatch("result transaction with nothing expected");
        end
        else
        begin
            want = expected_q.pop_front();
            compare_field("resend_setup", resend_setup, want.ack.resend_setup);
            compare_field("receiver_ready", receiver_ready, want.ack.receiver_ready);
            compare_field("char_valid", char_valid, want.ext.char_valid);
            compare_field("field_number", field_number, want.ext.field_number);
            compare_field("char_position", char_position, want.ext.char_position);
            compare_field("char_value", char_value, want.ext.char_value);
            compare_field("sentence_end", sentence_end, want.ext.sentence_end);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                check_result();
            end
            if (in_valid && !in_stall)
            begin
                extract_byte(rx_byte);
            end
        end
    end

    initial
    begin : result_sink
        int wait_n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                wait_n       = hold_request;
                hold_request = 0;
            end
            else
            begin
                wait_n = $urandom_range(0, rx_max_gap);
            end
            if (wait_n > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_n) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i]);
        end
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [7:0] pick_data_char();
        logic [7:0] c;
        string      compass;
        compass = "NSEWM";
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: c = 8'h30 + 8'($urandom_range(0, 9));
            6:                c = 8'h2E;
            7:                c = compass[$urandom_range(0, 4)];
            8:                c = 8'($urandom);
            default:          c = 8'h2D;
        endcase
        return c;
    endfunction

    task automatic send_random_sentence();
        int         kind;
        int         nfields;
        int         flen;
        int         bad_slot;
        logic [7:0] hdr [6];
        string      talker_ids;
        string      hex_digits;
        talker_ids = "PNLA";
        hex_digits = "0123456789ABCDEF";
        kind = $urandom_range(0, 15);
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        end
        else
        begin
            hdr[0] = CHAR_DOLLAR;
            hdr[1] = CHAR_G;
            hdr[2] = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                 : talker_ids[$urandom_range(0, 3)];
            hdr[3] = CHAR_G;
            hdr[4] = CHAR_G;
            hdr[5] = CHAR_A;
            if (kind == 1)
            begin
                bad_slot      = $urandom_range(1, 4);
                bad_slot      = (bad_slot == 2) ? 5 : bad_slot;
                hdr[bad_slot] = 8'($urandom);
            end
            for (int i = 0; i < 6; i++)
            begin
                send_byte(hdr[i]);
            end
            send_byte(($urandom_range(0, 7) == 0) ? 8'($urandom) : CHAR_COMMA);
            if (kind == 2)
            begin
                repeat (90)
                begin
                    send_byte(($urandom_range(0, 5) == 0) ? CHAR_COMMA : pick_data_char());
                end
            end
            else
            begin
                nfields = $urandom_range(0, 15);
                for (int f = 0; f < nfields; f++)
                begin
                    flen = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 20)
                                                       : $urandom_range(0, 6);
                    repeat (flen) send_byte(pick_data_char());
                    if (f != nfields - 1)
                    begin
                        send_byte(CHAR_COMMA);
                    end
                end
                send_byte(CHAR_STAR);
                send_byte(hex_digits[$urandom_range(0, 15)]);
                send_byte(hex_digits[$urandom_range(0, 15)]);
                if ($urandom_range(0, 1) == 1)
                begin
                    send_text("\r\n");
                end
            end
        end
    endtask

    task automatic test_ack_phase();
        int         plen;
        logic [7:0] b;
        logic [7:0] want;
        tx_max_gap = 14;
        rx_max_gap = 14;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hB5);
        send_byte(8'h62);
        send_byte(8'h05);
        send_byte(8'h01);
        send_byte(8'hB5);
        send_byte(8'hB5);
        send_byte(8'h62);
        send_byte(8'h00);
        for (int i = 0; i < 9; i++)
        begin
            send_byte(ACK_SEQUENCE[79 - 8 * i -: 8]);
        end
        send_byte(8'h00);
        repeat (20)
        begin
            plen = $urandom_range(0, 9);
            for (int i = 0; i < plen; i++)
            begin
                send_byte(ACK_SEQUENCE[79 - 8 * i -: 8]);
            end
            want = ACK_SEQUENCE[79 - 8 * plen -: 8];
            b    = 8'($urandom);
            if (b == want)
            begin
                b = b ^ 8'h01;
            end
            send_byte(b);
        end
        for (int i = 0; i < AckLen; i++)
        begin
            send_byte(ACK_SEQUENCE[79 - 8 * i -: 8]);
        end
        wait_for_results();
    endtask

    task automatic test_gga_sentences();
        tx_max_gap = 3;
        rx_max_gap = 3;
        send_text("xy$");
        send_text("GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47\r\n");
        send_text("$GNGGA,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,16,17*00");
        send_text("$GPGGA,0123456789ABCDEFGHIJ,x*");
        send_text("$GPRMC,123519,A*6A");
        send_text("$GP*");
        send_text("$GPGGA*");
        send_text("$GPGGAX12,$3*");
        send_text("$GPGGA,");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CHAR_STAR);
        send_text("$GPGGA,");
        for (int i = 0; i < 80; i++)
        begin
            send_byte((i % 7 == 6) ? CHAR_COMMA : 8'h30 + 8'(i % 10));
        end
        wait_for_results();
    endtask

    task automatic test_backpressure();
        tx_max_gap   = 0;
        rx_max_gap   = 0;
        hold_request = 300;
        send_text("$GPGGA,092750.000,5321.6802,N,00630.3372,W,1,8,1.03,61.7,M,55.2,M,,*76");
        wait_for_results();
        rx_max_gap = 14;
        send_text("$GLGGA,1,2,3,4,5,6,7,8,9,10,11,12*");
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        int start_count;
        int sentence_n;
        start_count = bytes_sent;
        sentence_n  = 0;
        while (bytes_sent < start_count + 1500)
        begin
            if (sentence_n % 20 == 0)
            begin
                tx_max_gap = (sentence_n % 60 == 0) ? 0 : 14;
                rx_max_gap = (sentence_n % 80 == 40) ? 0 : 14;
            end
            send_random_sentence();
            sentence_n++;
        end
    endtask

    task automatic finish_run();
        int guard;
        guard = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_q.size() != 0 && guard < 5000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (10) @(negedge clk);
        if (expected_q.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected results never arrived", expected_q.size()));
        end
        if (error_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        rx_byte      = 8'h00;
        error_count  = 0;
        bytes_sent   = 0;
        tx_max_gap   = 0;
        rx_max_gap   = 0;
        hold_request = 0;
        clear_model();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        test_ack_phase();
        test_gga_sentences();
        test_backpressure();
        test_random_traffic();
        finish_run();
    end

endmodule

// ----- filelist.f -----
rtl/core/gagfe_pkg.sv
rtl/core/gagfe_ack_match.sv
rtl/core/gagfe_gga_extract.sv
rtl/core/gps_ack_and_gga_field_extractor_top.sv
rtl/core/gagfe_checker.sv
verif/tb_gps_ack_and_gga_field_extractor_top.sv
